[sv/lavg_pkg.sv]
// Shared types, widths and constants of the limiting moving-average filter.
`timescale 1ns / 1ps
package lavg_pkg;

    localparam int WINDOW_LEN = 8;
    localparam int SAMPLE_W   = 16;
    localparam int LOG_LEN    = $clog2(WINDOW_LEN);
    localparam int SUM_W      = SAMPLE_W + LOG_LEN;
    localparam int IDX_W      = (WINDOW_LEN > 1) ? LOG_LEN : 1;

    // Reciprocal for the exact divide by WINDOW_LEN of a SUM_W-bit value.
    localparam int RSHIFT  = SUM_W + LOG_LEN;
    localparam int RECIP_W = SUM_W + 1;
    localparam longint RECIP_L =
        ((longint'(1) << RSHIFT) + longint'(WINDOW_LEN) - 1) / WINDOW_LEN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam int ADDR_W = 3;
    localparam logic [SAMPLE_W-1:0] JUMP_RESET = 16'd1;
    localparam logic [SAMPLE_W-1:0] REF_RESET  = 16'd300;

    typedef enum logic {
        REG_JUMP_LIMIT = 1'b0,
        REG_INIT_REF   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] jump_limit;
        logic                ref_load;
        logic [SAMPLE_W-1:0] ref_value;
    } t_cfg;

endpackage

[sv/lavg_regs.sv]
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module lavg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lavg_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output lavg_pkg::t_cfg                o_cfg
);
    import lavg_pkg::*;

    logic [SAMPLE_W-1:0] r_jump_limit;
    logic [SAMPLE_W-1:0] r_init_ref;
    logic                w_write;
    t_reg_idx            w_idx;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_idx   = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit <= JUMP_RESET;
            r_init_ref   <= REF_RESET;
        end else if (w_write) begin
            unique case (w_idx)
                REG_JUMP_LIMIT: r_jump_limit <= pwdata[SAMPLE_W-1:0];
                REG_INIT_REF:   r_init_ref   <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_JUMP_LIMIT: prdata = {16'd0, r_jump_limit};
            REG_INIT_REF:   prdata = {16'd0, r_init_ref};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg.jump_limit = r_jump_limit;
    assign o_cfg.ref_load   = w_write && (w_idx == REG_INIT_REF);
    assign o_cfg.ref_value  = pwdata[SAMPLE_W-1:0];

endmodule

[sv/lavg_core.sv]
// Jump limiter, sample window and running sum.
`timescale 1ns / 1ps
module lavg_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lavg_pkg::t_cfg               i_cfg,
    input  logic                         i_load,
    input  logic [lavg_pkg::SAMPLE_W-1:0] i_sample,
    output logic [lavg_pkg::SUM_W-1:0]   o_sum,
    output logic                         o_replaced
);
    import lavg_pkg::*;

    localparam logic [IDX_W-1:0] NEWEST = IDX_W'(WINDOW_LEN - 1);

    logic [SAMPLE_W-1:0] r_window [WINDOW_LEN];
    logic [SAMPLE_W-1:0] n_window [WINDOW_LEN];
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SAMPLE_W-1:0] w_last;
    logic [SAMPLE_W-1:0] w_diff;
    logic                w_replace;
    logic [SAMPLE_W-1:0] w_keep;

    assign w_last    = r_window[NEWEST];
    assign w_diff    = (i_sample > w_last) ? (i_sample - w_last) : (w_last - i_sample);
    assign w_replace = w_diff > i_cfg.jump_limit;
    assign w_keep    = w_replace ? w_last : i_sample;

    always_comb begin
        for (int k = 0; k < WINDOW_LEN; k++) begin
            n_window[k] = r_window[k];
        end
        n_sum = r_sum;
        if (i_cfg.ref_load) begin
            // Reseeding the newest slot keeps the sum in step with the window.
            n_window[NEWEST] = i_cfg.ref_value;
            n_sum = r_sum - SUM_W'(w_last) + SUM_W'(i_cfg.ref_value);
        end else if (i_load) begin
            for (int k = 0; k < WINDOW_LEN - 1; k++) begin
                n_window[k] = r_window[k + 1];
            end
            n_window[NEWEST] = w_keep;
            n_sum = r_sum - SUM_W'(r_window[0]) + SUM_W'(w_keep);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_window[k] <= (k == WINDOW_LEN - 1) ? REF_RESET : '0;
            end
            r_sum <= SUM_W'(REF_RESET);
        end else begin
            r_window <= n_window;
            r_sum    <= n_sum;
        end
    end

    // Stage result, taken by the divider together with the stage valid bit.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_sum      <= n_sum;
            o_replaced <= w_replace;
        end
    end

endmodule

[sv/lavg_div.sv]
// Exact divide of the window sum by the window length through a reciprocal.
`timescale 1ns / 1ps
module lavg_div (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [lavg_pkg::SUM_W-1:0]    i_sum,
    input  logic                          i_replaced,
    output logic [lavg_pkg::SAMPLE_W-1:0] o_average,
    output logic                          o_replaced
);
    import lavg_pkg::*;

    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_quot;

    assign w_prod = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign w_quot = w_prod >> RSHIFT;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_average  <= w_quot[SAMPLE_W-1:0];
            o_replaced <= i_replaced;
        end
    end

endmodule

[sv/limit_average_filter_top.sv]
// Top level of the amplitude-limiting moving-average filter.
`timescale 1ns / 1ps
// The filter takes one 16-bit sample per beat and returns one beat with the
// truncated mean of the last WINDOW_LEN accepted samples and a flag that
// says whether the sample was replaced. A sample whose absolute distance
// from the last accepted sample is strictly greater than jump_limit is
// replaced by that last accepted sample. A new sample can be taken in every
// cycle in which o_ready is high. The first stage updates the window and
// running sum, the second divides the sum by the window length with a
// constant reciprocal multiply. The two stages advance together, so a
// stalled result holds the stage behind it and o_ready drops only while a
// result waits and i_ready is low. After reset the window is all zeros
// except the newest slot, which holds the initial reference (300).
// Register 0 (address 0) is jump_limit, register 1 (address 4) is
// initial_reference; writing register 1 reloads the newest slot and
// corrects the sum. Write registers only while the filter is idle.
module limit_average_filter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lavg_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lavg_pkg::SAMPLE_W-1:0] o_average,
    output logic                          o_sample_replaced,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lavg_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lavg_pkg::*;

    t_cfg             w_cfg;
    logic             w_adv;
    logic             w_in_take;
    logic             r_s1_valid;
    logic             r_out_valid;
    logic [SUM_W-1:0] w_s1_sum;
    logic             w_s1_replaced;

    // The whole pipeline moves whenever the output register is free or
    // being emptied in this cycle.
    assign w_adv     = !r_out_valid || i_ready;
    assign o_ready   = w_adv;
    assign w_in_take = i_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_in_take;
            r_out_valid <= r_s1_valid;
        end
    end

    lavg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lavg_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_load     (w_in_take),
        .i_sample   (i_sample),
        .o_sum      (w_s1_sum),
        .o_replaced (w_s1_replaced)
    );

    lavg_div u_div (
        .i_clk      (i_clk),
        .i_load     (w_adv && r_s1_valid),
        .i_sum      (w_s1_sum),
        .i_replaced (w_s1_replaced),
        .o_average  (o_average),
        .o_replaced (o_sample_replaced)
    );

    assign o_valid = r_out_valid;

endmodule

[sv/lavg_checker.sv]
// Port-level checks of the filter and the bind that attaches them.
`timescale 1ns / 1ps
module lavg_port_checks (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [lavg_pkg::SAMPLE_W-1:0] o_average,
    input logic                          o_sample_replaced,
    input logic                          pready
);
    import lavg_pkg::*;

    // A result beat that is held back keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_average) && $stable(o_sample_replaced))
        else $error("stalled result changed");

    // With nothing waiting at the output the filter is always ready for a sample.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output empty");

    // A taken sample reaches the output if the pipeline keeps moving.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready ##1 o_ready |=> o_valid)
        else $error("result missing after two cycles");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind limit_average_filter_top lavg_port_checks u_lavg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_average         (o_average),
    .o_sample_replaced (o_sample_replaced),
    .pready            (pready)
);

[verif/lavg_checker.sv]
// Scoreboard for the limiting moving-average filter: predicts and compares each result beat.
`timescale 1ns / 1ps
module lavg_checker
    import lavg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [SAMPLE_W-1:0] i_average,
    input  logic                i_sample_replaced,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_error_count,
    output int                  o_pending_count
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                replaced;
    } t_filter_result;

    t_filter_result      awaited_results[$];
    logic [SAMPLE_W-1:0] jump_lim;
    logic [SAMPLE_W-1:0] seed_value;
    logic [SAMPLE_W-1:0] hist [WINDOW_LEN];
    logic [21:0]         hist_sum;

    task automatic clear_history();
        for (int k = 0; k < WINDOW_LEN; k++) begin
            hist[k] = '0;
        end
        jump_lim               = JUMP_RESET;
        seed_value             = REF_RESET;
        hist[WINDOW_LEN-1]     = REF_RESET;
        hist_sum               = 22'(REF_RESET);
        awaited_results.delete();
    endtask

    // Limit the raw sample against the newest slot, shift it in and queue the mean.
    task automatic filter_sample(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] newest;
        logic [SAMPLE_W-1:0] taken;
        int                  step_abs;
        t_filter_result      res;
        newest   = hist[WINDOW_LEN-1];
        step_abs = int'(raw) - int'(newest);
        if (step_abs < 0) begin
            step_abs = -step_abs;
        end
        taken        = raw;
        res.replaced = 1'b0;
        if (step_abs > int'(jump_lim)) begin
            taken        = newest;
            res.replaced = 1'b1;
        end
        hist_sum = hist_sum - 22'(hist[0]) + 22'(taken);
        for (int k = 0; k + 1 < WINDOW_LEN; k++) begin
            hist[k] = hist[k+1];
        end
        hist[WINDOW_LEN-1] = taken;
        res.average        = SAMPLE_W'(hist_sum / WINDOW_LEN);
        awaited_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_filter_result want;
        if (!i_rst_n) begin
            clear_history();
            o_error_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with none awaited: average %h replaced %b",
                             $time, i_average, i_sample_replaced);
                    o_error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_average !== want.average) begin
                        $display("%0t: average mismatch: expected %h actual %h",
                                 $time, want.average, i_average);
                        o_error_count++;
                    end
                    if (i_sample_replaced !== want.replaced) begin
                        $display("%0t: sample_replaced mismatch: expected %b actual %b",
                                 $time, want.replaced, i_sample_replaced);
                        o_error_count++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_JUMP_LIMIT: begin
                        jump_lim = i_pwdata[SAMPLE_W-1:0];
                    end
                    REG_INIT_REF: begin
                        seed_value         = i_pwdata[SAMPLE_W-1:0];
                        hist_sum           = hist_sum - 22'(hist[WINDOW_LEN-1])
                                             + 22'(seed_value);
                        hist[WINDOW_LEN-1] = seed_value;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                filter_sample(i_sample);
            end
        end
        o_pending_count = awaited_results.size();
    end

endmodule

[verif/testbench.sv]
// Top of the filter testbench: clock, reset, sample and register stimulus, and the verdict.
`timescale 1ns / 1ps
module testbench;
    import lavg_pkg::*;

    // Generous ceiling on the run length in clock cycles.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 108;
    localparam int PHASES      = 6;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [SAMPLE_W-1:0] i_sample = '0;
    logic                i_ready = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [31:0]         pwdata  = '0;

    logic                o_ready;
    logic                o_valid;
    logic [SAMPLE_W-1:0] o_average;
    logic                o_sample_replaced;
    logic [31:0]         prdata;
    logic                pready;

    int                  error_count;
    int                  pending_count;
    int                  cycle_count  = 0;
    int                  samples_sent = 0;
    int                  reg_writes   = 0;
    logic [SAMPLE_W-1:0] prev_sample  = '0;

    limit_average_filter_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_average         (o_average),
        .o_sample_replaced (o_sample_replaced),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // The scoreboard watches both streams and the register port on its own;
    // this module only makes stimulus and reads back the failure and pending counts.
    lavg_checker scoreboard (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_sample          (i_sample),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_average         (o_average),
        .i_sample_replaced (o_sample_replaced),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_error_count     (error_count),
        .o_pending_count   (pending_count)
    );

    initial begin
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    // A hung handshake must not hang the run. The counter ends it with a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    // The receiver switches between stall patterns of random length: always
    // ready, coin-flip, mostly stalled, and a fixed on-off rhythm from cycle_count[2].
    // Mode changes are independent of the sender, so stalls land on every
    // phase of the two-stage pipeline, including right behind a full stage.
    int stall_mode = 0;
    int mode_left  = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= cycle_count[2];
        endcase
    end

    // Present one sample and hold it until the filter takes the beat. The
    // caller stands at a rising edge, so valid stays high across back-to-back
    // beats with only a payload update in between.
    task automatic drive_sample(input logic [SAMPLE_W-1:0] value);
        i_valid  <= 1'b1;
        i_sample <= value;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        prev_sample = value;
        samples_sent++;
    endtask

    // Drop valid and wait until every result has come back. The first edge
    // lets the scoreboard count a beat taken on the edge we arrived on; the
    // trailing cycles let the pipeline settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready. The upper
    // half of the data word carries random junk that the filter must drop.
    task automatic write_reg(input t_reg_idx idx, input logic [SAMPLE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    // Mostly a random walk around the previous sample with steps sized to the
    // jump limit, plus steps right at the limit and one past it, then full
    // random words and the two rails as noise.
    function automatic logic [SAMPLE_W-1:0] next_sample(input logic [SAMPLE_W-1:0] prev,
                                                         input logic [SAMPLE_W-1:0] lim);
        int pick;
        int delta;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            delta = $urandom_range(0, lim);
        end else if (pick < 75) begin
            delta = int'(lim) + $urandom_range(0, 1);
        end else if (pick < 90) begin
            return SAMPLE_W'($urandom());
        end else begin
            return pick[0] ? '1 : '0;
        end
        v = $urandom_range(0, 1) ? int'(prev) + delta : int'(prev) - delta;
        if (v < 0) begin
            v = 0;
        end else if (v > 65535) begin
            v = 65535;
        end
        return SAMPLE_W'(v);
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] at_reset [8]  = '{16'd300, 16'd301, 16'd303, 16'd300,
                                              16'd0, 16'hFFFF, 16'd299, 16'd300};
        logic [SAMPLE_W-1:0] wide_open [6] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
                                              16'hAAAA, 16'h5555};
        logic [SAMPLE_W-1:0] shut [5]      = '{16'd0, 16'd0, 16'd1, 16'hFFFF, 16'h8000};
        logic [SAMPLE_W-1:0] lim;
        logic [SAMPLE_W-1:0] seed;
        int                  sent;
        int                  burst;
        int                  gap;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a limit of one around the seed of 300. Covers a
        // zero step, a step equal to the limit, one past it, and both rails.
        foreach (at_reset[k]) begin
            drive_sample(at_reset[k]);
        end
        wait_idle();

        // Widest limit: a full-scale swing equals the limit and is kept.
        write_reg(REG_JUMP_LIMIT, 16'hFFFF);
        foreach (wide_open[k]) begin
            drive_sample(wide_open[k]);
        end
        wait_idle();

        // Zero limit with a zero seed: only a repeat of the last value passes.
        write_reg(REG_JUMP_LIMIT, 16'd0);
        write_reg(REG_INIT_REF, 16'd0);
        foreach (shut[k]) begin
            drive_sample(shut[k]);
        end

        // Random phases, each under its own limit and seed. The seed write
        // lands on a window already holding history, which exercises the
        // reload of the newest slot and the sum correction.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    lim  = 16'd0;
                    seed = 16'd0;
                end
                1: begin
                    lim  = 16'hFFFF;
                    seed = 16'hFFFF;
                end
                2: begin
                    lim  = SAMPLE_W'($urandom_range(1, 16));
                    seed = SAMPLE_W'($urandom());
                end
                3: begin
                    lim  = SAMPLE_W'($urandom_range(100, 2000));
                    seed = SAMPLE_W'($urandom());
                end
                4: begin
                    lim  = SAMPLE_W'($urandom());
                    seed = SAMPLE_W'($urandom());
                end
                default: begin
                    lim  = JUMP_RESET;
                    seed = REF_RESET;
                end
            endcase
            write_reg(REG_JUMP_LIMIT, lim);
            write_reg(REG_INIT_REF, seed);
            prev_sample = seed;

            // Bursts of random length, now and then a long unbroken one,
            // separated by gaps that are sometimes zero.
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 24);
                for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
                    drive_sample(next_sample(prev_sample, lim));
                    sent++;
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        // Drain: every result back, then a few quiet cycles in which any
        // stray beat would still be flagged by the scoreboard.
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d samples and %0d register writes over %0d random phases,",
                 samples_sent, reg_writes, PHASES);
        $display("with limits from zero to full scale, bursty input and output stalls.");
        if (error_count == 0 && pending_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived", error_count, pending_count);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
